@@ rtl/cfa_pkg.sv @@
package cfa_pkg;

    localparam int unsigned OffW   = 15;
    localparam int unsigned AlignW = 7;
    localparam int unsigned AddrW  = 64;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned CfgW   = 15;

    // instruction opcodes
    localparam logic [ByteW-1:0] OP_NOP            = 8'h00;
    localparam logic [ByteW-1:0] OP_DEF_CFA        = 8'h0c;
    localparam logic [ByteW-1:0] OP_DEF_CFA_OFFSET = 8'h0e;
    localparam logic [ByteW-1:0] OP_DEF_CFA_SF     = 8'h12;
    localparam logic [1:0]       OP_HI_ADVANCE     = 2'b01;
    localparam logic [1:0]       OP_HI_OFFSET      = 2'b10;

    // item kinds
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    // configuration register indexes
    localparam logic CFG_INITIAL_CFA_OFFSET = 1'b0;
    localparam logic CFG_CODE_ALIGN         = 1'b1;

    typedef enum logic [1:0] {
        ST_END  = 2'd0,
        ST_PAST = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        PH_OPCODE = 5'b00001,
        PH_REG    = 5'b00010,
        PH_SCALED = 5'b00100,
        PH_DIRECT = 5'b01000,
        PH_SKIP   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic             action;
        logic [ByteW-1:0] data_byte;
        logic [AddrW-1:0] start_address;
        logic [AddrW-1:0] target_address;
        logic             last_byte;
    } item_t;

    typedef struct packed {
        logic            valid;
        logic [OffW-1:0] cfa_offset;
        status_t         status;
    } result_t;

endpackage

@@ rtl/cfa_opcode_interpreter_unit.sv @@
// call-frame instruction interpreter
//
// slave channel: one beat per item. s_tuser[0] is the kind (0 start, 1 byte).
// a start beat loads the start and target addresses and the initial offset
// and never gives a result. byte beats walk the instruction program; s_tlast
// marks the last byte of the program.
// master channel: at most one result beat per program: the offset in force
// and a status (0 program ended, 1 stopped past target, 2 unknown opcode).
// after a result, bytes are dropped until the next start beat.
// configuration: cfg_we writes register cfg_index (0 initial offset, 1 code
// alignment); write only while the block is idle: the block does not enforce it.
// path: a beat is registered in the input register and interpreted from there;
// its result is registered in the output register before it shows on the master side.
// throughput: one beat per cycle while the receiver does not stall; each beat takes one
// combinational step of the interpreter (a small multiply, a 64-bit add and a compare).
// reset clears the interpreter state, both registers to their defaults
// (offset 0, alignment 1) and all valid flags.
// when the receiver stalls, the result beat holds and one more input beat
// is held in the input register before s_tready drops.
module cfa_opcode_interpreter_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [135:0]                s_tdata,  // data_byte, start_address, target_address
    input  logic                        s_tlast,
    input  logic [0:0]                  s_tuser,  // action
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,  // cfa_offset, zero pad
    output logic [1:0]                  m_tuser,  // status
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [cfa_pkg::CfgW-1:0]    cfg_data
);
    import cfa_pkg::*;

    logic              in_valid_reg;
    item_t             in_item_reg;
    logic              out_valid_reg;
    logic [OffW-1:0]   out_offset_reg;
    status_t           out_status_reg;
    logic [OffW-1:0]   init_offset_reg;
    logic [AlignW-1:0] code_align_reg;
    logic              proc_fire;
    logic              in_fire;
    item_t             in_item;
    result_t           res;

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign in_fire   = s_tvalid && s_tready;

    assign in_item.action         = s_tuser[0];
    assign in_item.data_byte      = s_tdata[7:0];
    assign in_item.start_address  = s_tdata[71:8];
    assign in_item.target_address = s_tdata[135:72];
    assign in_item.last_byte      = s_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            init_offset_reg <= '0;
            code_align_reg  <= AlignW'(1);
        end
        else
        begin
            if (in_fire)
                in_valid_reg <= 1'b1;
            else if (proc_fire)
                in_valid_reg <= 1'b0;

            if (proc_fire)
                out_valid_reg <= res.valid;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_INITIAL_CFA_OFFSET: init_offset_reg <= cfg_data[OffW-1:0];
                    CFG_CODE_ALIGN:         code_align_reg  <= cfg_data[AlignW-1:0];
                    default:                ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            in_item_reg <= in_item;
        if (proc_fire && res.valid)
        begin
            out_offset_reg <= res.cfa_offset;
            out_status_reg <= res.status;
        end
    end

    cfa_core u_core (
        .clk                (clk),
        .rst_n              (rst_n),
        .fire               (proc_fire),
        .item               (in_item_reg),
        .initial_cfa_offset (init_offset_reg),
        .code_align         (code_align_reg),
        .res                (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_offset_reg};
    assign m_tuser  = out_status_reg;

endmodule

@@ rtl/cfa_core.sv @@
module cfa_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  cfa_pkg::item_t                item,
    input  logic [cfa_pkg::OffW-1:0]      initial_cfa_offset,
    input  logic [cfa_pkg::AlignW-1:0]    code_align,
    output cfa_pkg::result_t              res
);
    import cfa_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [OffW-1:0]  offset_reg, offset_next;
    logic [AddrW-1:0] location_reg, location_next;
    logic [AddrW-1:0] target_reg, target_next;
    logic             finished_reg, finished_next;

    logic [ByteW-1:0]          b;
    logic [5+AlignW:0]         delta;
    logic [AddrW:0]            sum;
    logic [AddrW-1:0]          loc_adv;
    logic                      overflow;
    logic [ByteW+AlignW-1:0]   scaled;
    logic                      done;
    logic                      bad;
    logic                      advance;

    assign b        = item.data_byte;
    assign delta    = b[5:0] * code_align;
    assign sum      = {1'b0, location_reg} + {{(AddrW-5-AlignW){1'b0}}, delta};
    assign overflow = sum[AddrW];
    assign loc_adv  = overflow ? {AddrW{1'b1}} : sum[AddrW-1:0];
    assign scaled   = b * code_align;

    always_comb
    begin
        phase_next    = phase_reg;
        offset_next   = offset_reg;
        location_next = location_reg;
        target_next   = target_reg;
        finished_next = finished_reg;
        done          = 1'b0;
        bad           = 1'b0;
        advance       = 1'b0;
        res.valid      = 1'b0;
        res.cfa_offset = offset_reg;
        res.status     = ST_END;

        if (fire && item.action == ACT_START)
        begin
            location_next = item.start_address;
            target_next   = item.target_address;
            offset_next   = initial_cfa_offset;
            phase_next    = PH_OPCODE;
            finished_next = 1'b0;
        end
        else if (fire && !finished_reg)
        begin
            unique case (phase_reg)
                PH_OPCODE:
                begin
                    priority if (b == OP_NOP)
                        done = 1'b1;
                    else if (b == OP_DEF_CFA || b == OP_DEF_CFA_SF)
                        phase_next = PH_REG;
                    else if (b == OP_DEF_CFA_OFFSET)
                        phase_next = PH_DIRECT;
                    else if (b[7:6] == OP_HI_ADVANCE)
                    begin
                        advance = 1'b1;
                        done    = 1'b1;
                    end
                    else if (b[7:6] == OP_HI_OFFSET)
                        phase_next = PH_SKIP;
                    else
                        bad = 1'b1;
                end
                PH_REG:
                    phase_next = PH_SCALED;
                PH_SCALED:
                begin
                    offset_next = scaled[OffW-1:0];
                    phase_next  = PH_OPCODE;
                    done        = 1'b1;
                end
                PH_DIRECT:
                begin
                    offset_next = {{(OffW-ByteW){1'b0}}, b};
                    phase_next  = PH_OPCODE;
                    done        = 1'b1;
                end
                PH_SKIP:
                begin
                    phase_next = PH_OPCODE;
                    done       = 1'b1;
                end
                default:
                    phase_next = PH_OPCODE;
            endcase

            if (advance)
                location_next = loc_adv;

            res.cfa_offset = offset_next;
            priority if (bad)
            begin
                res.valid  = 1'b1;
                res.status = ST_BAD;
            end
            else if (done && ((advance && overflow) || location_next > target_reg))
            begin
                res.valid  = 1'b1;
                res.status = ST_PAST;
            end
            else if (item.last_byte)
            begin
                res.valid  = 1'b1;
                res.status = ST_END;
            end

            if (res.valid)
            begin
                finished_next = 1'b1;
                phase_next    = PH_OPCODE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_OPCODE;
            offset_reg   <= '0;
            location_reg <= '0;
            target_reg   <= '0;
            finished_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            offset_reg   <= offset_next;
            location_reg <= location_next;
            target_reg   <= target_next;
            finished_reg <= finished_next;
        end
    end

    a_res_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> fire && item.action == ACT_BYTE && !finished_reg)
        else $error("result without an accepted instruction byte");

    a_start_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.action == ACT_START |=> !finished_reg && phase_reg == PH_OPCODE)
        else $error("start did not rearm the interpreter");

    a_result_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |=> finished_reg && phase_reg == PH_OPCODE)
        else $error("interpreter not finished after a result");

    a_location_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.action == ACT_BYTE |=> location_reg >= $past(location_reg))
        else $error("location moved backward on a byte");

endmodule
